// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL, included by sequence_reorder_buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on rising clk, suppressed while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on rising clk, also during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/srb_pkg.sv -----
// ----------------------------------------------------------------------------
// srb_pkg
// Types and constants of the sequence reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

  localparam int WINDOW = 32;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SEQ_W  = 31;
  localparam int PAY_W  = 32;
  localparam int LEN_W  = 16;
  localparam int ST_W   = 2;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_DELIVER = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_READ  = 4'b0100,
    S_DELIV = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/srb_if.sv -----
// ----------------------------------------------------------------------------
// srb_if
// Valid/ready channels of the sequence reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

interface srb_in_if;
  logic                     valid;
  logic                     ready;
  logic [srb_pkg::SEQ_W-1:0] seq_num;
  logic [srb_pkg::PAY_W-1:0] payload_handle;
  logic [srb_pkg::LEN_W-1:0] payload_length;
  logic                     is_end;

  modport source (output valid, seq_num, payload_handle, payload_length, is_end,
                  input ready);
  modport sink   (input valid, seq_num, payload_handle, payload_length, is_end,
                  output ready);
endinterface

interface srb_out_if;
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic [srb_pkg::SEQ_W-1:0] seq_out;
  logic [srb_pkg::PAY_W-1:0] payload_out;
  logic [srb_pkg::LEN_W-1:0] length_out;
  logic [srb_pkg::ST_W-1:0]  status;
  logic                     last;

  modport source (output valid, result_kind, seq_out, payload_out, length_out,
                  status, last, input ready);
  modport sink   (input valid, result_kind, seq_out, payload_out, length_out,
                  status, last, output ready);
endinterface

interface srb_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [srb_pkg::SEQ_W-1:0] first_sequence;

  modport source (output valid, first_sequence, input ready);
  modport sink   (input valid, first_sequence, output ready);
endinterface

`default_nettype wire

// ----- rtl/sequence_reorder_buffer.sv -----
// An item is taken in IDLE; its acknowledgement word is loaded in CALC once the output
// register is free. No new item is taken until the last one and its releases are done;
// releases use the registered slot memory read and the one shared 31-bit adder.
// Reset (rst_n low, synchronous): expected number 1, all slots empty, not finished.
// A cfg word restarts the block the same way with the written expected number.
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Acknowledges packets, parks them by sequence number in a window of slots
// and releases consecutive packets in order from the expected number on.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_reorder_buffer (
  input  wire logic clk,
  input  wire logic rst_n,
  srb_in_if.sink    in_if,
  srb_out_if.source out_if,
  srb_cfg_if.sink   cfg_if
);
  import srb_pkg::*;

  `include "assert_macros.svh"

  state_t state_r, state_nxt;
  logic   finished_r, finished_nxt;
  seq_t   next_exp_r, next_exp_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;

  // captured input word
  seq_t              seq_r;
  logic [PAY_W-1:0]  pay_r;
  logic [LEN_W-1:0]  len_r;
  logic              end_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  seq_t              oseq_r, oseq_nxt;
  logic [PAY_W-1:0]  opay_r, opay_nxt;
  logic [LEN_W-1:0]  olen_r, olen_nxt;
  status_t           ost_r, ost_nxt;
  logic              olast_r, olast_nxt;

  // slot memory
  logic [PAY_W+LEN_W-1:0] mem [WINDOW];
  logic [PAY_W+LEN_W-1:0] rd_q_r;
  logic                   mem_we;

  // shared add/subtract unit
  logic  alu_sub;
  seq_t  alu_res;
  slot_t exp_slot, seq_slot, nxt_slot;
  status_t st;
  logic  in_acc, out_free, more;

  // increment only while releasing, subtract for the window test otherwise
  assign alu_sub  = (state_r != S_DELIV);
  assign alu_res  = alu_sub ? seq_t'(seq_r - next_exp_r) : seq_t'(next_exp_r + seq_t'(1));
  assign exp_slot = slot_t'(next_exp_r % WINDOW);
  assign seq_slot = slot_t'(seq_r % WINDOW);
  assign nxt_slot = slot_t'(alu_res % WINDOW);

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.result_kind = kind_r;
  assign out_if.seq_out     = oseq_r;
  assign out_if.payload_out = opay_r;
  assign out_if.length_out  = olen_r;
  assign out_if.status      = ost_r;
  assign out_if.last        = olast_r;

  always_comb begin
    // window classification of seq_r - next_exp_r
    if (alu_res < seq_t'(WINDOW)) begin
      st = ST_OK;
    end else if (alu_res[SEQ_W-1]) begin
      st = ST_DUP;
    end else begin
      st = ST_BEYOND;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    finished_nxt  = finished_r;
    next_exp_nxt  = next_exp_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    kind_nxt      = kind_r;
    oseq_nxt      = oseq_r;
    opay_nxt      = opay_r;
    olen_nxt      = olen_r;
    ost_nxt       = ost_r;
    olast_nxt     = olast_r;
    mem_we        = 1'b0;
    more          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc && !finished_r) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_ACK;
          oseq_nxt      = seq_r;
          opay_nxt      = '0;
          olen_nxt      = '0;
          cnt_nxt       = '0;
          if (end_r) begin
            ost_nxt      = ST_OK;
            olast_nxt    = 1'b1;
            finished_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            ost_nxt = st;
            if (st == ST_OK) begin
              mem_we              = 1'b1;
              valid_nxt[seq_slot] = 1'b1;
              more = (seq_slot == exp_slot) || valid_r[exp_slot];
            end
            olast_nxt = !more;
            state_nxt = more ? S_READ : S_IDLE;
          end
        end
      end
      S_READ: begin
        // rd_q_r picks up the expected slot at this edge
        state_nxt = S_DELIV;
      end
      S_DELIV: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          kind_nxt            = KIND_DELIVER;
          oseq_nxt            = next_exp_r;
          opay_nxt            = rd_q_r[PAY_W-1:0];
          olen_nxt            = rd_q_r[PAY_W+LEN_W-1:PAY_W];
          ost_nxt             = ST_OK;
          valid_nxt[exp_slot] = 1'b0;
          next_exp_nxt        = alu_res;
          cnt_nxt             = cnt_r + cnt_t'(1);
          more = valid_r[nxt_slot] && (nxt_slot != exp_slot)
                 && (cnt_r != cnt_t'(WINDOW - 1));
          olast_nxt = !more;
          state_nxt = more ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_if.valid) begin
      next_exp_nxt = cfg_if.first_sequence;
      valid_nxt    = '0;
      finished_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      finished_r  <= 1'b0;
      next_exp_r  <= seq_t'(1);
      cnt_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      finished_r  <= finished_nxt;
      next_exp_r  <= next_exp_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      seq_r <= in_if.seq_num;
      pay_r <= in_if.payload_handle;
      len_r <= in_if.payload_length;
      end_r <= in_if.is_end;
    end
    kind_r  <= kind_nxt;
    oseq_r  <= oseq_nxt;
    opay_r  <= opay_nxt;
    olen_r  <= olen_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[seq_slot] <= {len_r, pay_r};
    end
    rd_q_r <= mem[exp_slot];
  end

  `ASSERT_CLK(a_read_valid_slot, (state_r == S_READ) |-> valid_r[exp_slot],
              "release started on an empty slot")
  `ASSERT_CLK(a_drain_bound, cnt_r <= cnt_t'(WINDOW),
              "release run longer than the window")
  `ASSERT_CLK(a_finished_drop, (in_acc && finished_r) |=> (state_r == S_IDLE),
              "word taken after end packet was processed")
  `ASSERT_ALWAYS(a_reset_idle, $past(!rst_n) |-> (state_r == S_IDLE && !out_valid_r),
                 "sequencer not idle after reset")

endmodule

`default_nettype wire

// ----- tb/srb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_checker
// Watches the packet, result and cfg channels of the reorder buffer. Keeps its
// own copy of the window slots and the expected number, predicts the ack and
// release words of every accepted packet up to the end packet, and compares them in order.
// ----------------------------------------------------------------------------

module srb_checker (
  input  logic clk,
  input  logic rst_n,
  srb_in_if    in_mon,
  srb_out_if   out_mon,
  srb_cfg_if   cfg_mon,
  output int   errors,
  output int   pending
);
  import srb_pkg::*;

  localparam seq_t HALF_SPACE = 31'h4000_0000;

  typedef struct packed {
    kind_t            kind;
    seq_t             seq;
    logic [PAY_W-1:0] pay;
    logic [LEN_W-1:0] len;
    status_t          status;
    logic             last;
  } result_word_t;

  logic             slot_full [WINDOW];
  logic [PAY_W-1:0] slot_pay  [WINDOW];
  logic [LEN_W-1:0] slot_len  [WINDOW];
  seq_t             exp_seq;
  logic             stopped;

  result_word_t due_words[$];
  result_word_t got_w;
  result_word_t want_w;
  int           err_cnt;

  function automatic result_word_t make_word(kind_t kind, seq_t seq,
                                             logic [PAY_W-1:0] pay,
                                             logic [LEN_W-1:0] len,
                                             status_t status);
    result_word_t w;
    w.kind   = kind;
    w.seq    = seq;
    w.pay    = pay;
    w.len    = len;
    w.status = status;
    w.last   = 1'b0;
    return w;
  endfunction

  function automatic string word_str(result_word_t w);
    return $sformatf("kind=%0d seq=%h pay=%h len=%h status=%0d last=%0d",
                     w.kind, w.seq, w.pay, w.len, w.status, w.last);
  endfunction

  task automatic restart_window(input seq_t first);
    for (int i = 0; i < WINDOW; i++) begin
      slot_full[i] = 1'b0;
    end
    exp_seq = first;
    stopped = 1'b0;
  endtask

  // Ack first, then every consecutive parked packet from the expected number on.
  task automatic track_packet(input seq_t seq, input logic [PAY_W-1:0] pay,
                              input logic [LEN_W-1:0] len, input logic is_end);
    result_word_t batch[$];
    seq_t         gap;
    status_t      st;
    slot_t        slot;
    if (stopped) return;
    if (is_end) begin
      batch.push_back(make_word(KIND_ACK, seq, '0, '0, ST_OK));
      stopped = 1'b1;
    end else begin
      gap = seq - exp_seq;
      if (gap < seq_t'(WINDOW)) st = ST_OK;
      else if (gap >= HALF_SPACE) st = ST_DUP;
      else st = ST_BEYOND;
      batch.push_back(make_word(KIND_ACK, seq, '0, '0, st));
      if (st == ST_OK) begin
        slot = slot_t'(seq % WINDOW);
        slot_full[slot] = 1'b1;
        slot_pay[slot]  = pay;
        slot_len[slot]  = len;
        for (int i = 0; i < WINDOW; i++) begin
          slot = slot_t'(exp_seq % WINDOW);
          if (!slot_full[slot]) break;
          batch.push_back(make_word(KIND_DELIVER, exp_seq, slot_pay[slot],
                                    slot_len[slot], ST_OK));
          slot_full[slot] = 1'b0;
          exp_seq = exp_seq + 1'b1;
        end
      end
    end
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_words.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_window(seq_t'(1));
      due_words.delete();
      err_cnt = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        restart_window(cfg_mon.first_sequence);
      end
      if (in_mon.valid && in_mon.ready) begin
        track_packet(in_mon.seq_num, in_mon.payload_handle, in_mon.payload_length,
                     in_mon.is_end);
      end
      if (out_mon.valid && out_mon.ready) begin
        got_w.kind   = kind_t'(out_mon.result_kind);
        got_w.seq    = out_mon.seq_out;
        got_w.pay    = out_mon.payload_out;
        got_w.len    = out_mon.length_out;
        got_w.status = status_t'(out_mon.status);
        got_w.last   = out_mon.last;
        if (due_words.size() == 0) begin
          err_cnt++;
          $display("%0t ns: unexpected word, expected none, actual %s",
                   $time, word_str(got_w));
        end else begin
          want_w = due_words.pop_front();
          if (got_w.kind !== want_w.kind || got_w.seq !== want_w.seq ||
              got_w.pay !== want_w.pay || got_w.len !== want_w.len ||
              got_w.status !== want_w.status || got_w.last !== want_w.last) begin
            err_cnt++;
            $display("%0t ns: word mismatch, expected %s, actual %s",
                     $time, word_str(want_w), word_str(got_w));
          end
        end
      end
    end
    errors  <= err_cnt;
    pending <= due_words.size();
  end

endmodule

// ----- tb/tb_sequence_reorder_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_reorder_buffer
// Drives packets and cfg words into the reorder buffer: a directed pass over
// window edges, duplicates, wrap and end handling, then random runs of
// shuffled or descending packets with noise under several idle/stall patterns.
// ----------------------------------------------------------------------------

module tb_sequence_reorder_buffer;
  import srb_pkg::*;

  localparam int SETTLE_CYCLES   = 100;
  localparam int WORDS_PER_PHASE = 90;

  logic clk;
  logic rst_n;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   sent_words;
  int   fail_cnt;
  int   due_cnt;
  seq_t next_seq;

  srb_in_if  in_ch ();
  srb_out_if out_ch ();
  srb_cfg_if cfg_ch ();

  sequence_reorder_buffer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  srb_checker u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .errors  (fail_cnt),
    .pending (due_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_packet(input seq_t seq, input logic [PAY_W-1:0] pay,
                             input logic [LEN_W-1:0] len, input logic is_end);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.seq_num        <= seq;
    in_ch.payload_handle <= pay;
    in_ch.payload_length <= len;
    in_ch.is_end         <= is_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_data(input seq_t seq);
    send_packet(seq, $urandom, LEN_W'($urandom), 1'b0);
    sent_words++;
  endtask

  // Lower valid and wait until every predicted word is out.
  task automatic settle(input int extra);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_cnt != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_first_seq(input seq_t value);
    @(negedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.first_sequence <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    next_seq = value;
  endtask

  // Noise behind or beyond the window of the current run, a random number, or a repeat of the previous packet.
  task automatic send_noise(input seq_t base, input int len_run, input seq_t prev,
                            input bit have_prev);
    case ($urandom_range(3))
      0: send_data(base - seq_t'($urandom_range(1, 40)));
      1: send_data(base + seq_t'(len_run + WINDOW + $urandom_range(0, 64)));
      2: send_data(seq_t'($urandom));
      default: send_data(have_prev ? prev : base - 1'b1);
    endcase
  endtask

  task automatic send_run(input int len_run, input bit descending);
    seq_t order[$];
    seq_t base;
    seq_t tmp;
    int   j;
    base = next_seq;
    for (int i = 0; i < len_run; i++) begin
      order.push_back(descending ? base + seq_t'(len_run - 1 - i) : base + seq_t'(i));
    end
    if (!descending) begin
      for (int i = len_run - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    foreach (order[i]) begin
      if ($urandom_range(99) < 12) begin
        send_noise(base, len_run, (i > 0) ? order[i-1] : base, i > 0);
      end
      send_data(order[i]);
    end
    next_seq = base + seq_t'(len_run);
  endtask

  initial begin
    int quota;
    int run_cnt;
    in_ch.valid           = 1'b0;
    in_ch.seq_num         = '0;
    in_ch.payload_handle  = '0;
    in_ch.payload_length  = '0;
    in_ch.is_end          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.first_sequence = '0;
    rst_n                 = 1'b0;
    sent_words            = 0;
    next_seq              = seq_t'(1);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass, expected number 1 after reset
    send_packet(seq_t'(1), '0, '0, 1'b0);
    send_packet(seq_t'(1), '1, '1, 1'b0);                 // just behind: duplicate
    send_packet(seq_t'(2 + WINDOW), $urandom, '1, 1'b0);  // one past window edge
    send_packet(seq_t'(1 + WINDOW), '1, '1, 1'b0);        // last slot in window
    send_packet(seq_t'(1 + WINDOW), $urandom, 16'h1234, 1'b0);
    send_packet(seq_t'(2) + 31'h4000_0000, $urandom, '0, 1'b0);
    send_packet(seq_t'(1) + 31'h4000_0000, $urandom, '0, 1'b0);
    send_packet(seq_t'(3), 32'hA5A5_5A5A, 16'h00FF, 1'b0);
    send_packet(seq_t'(2), 32'h5A5A_A5A5, 16'hFF00, 1'b0);
    send_packet(31'h7FFF_FFFF, '1, '1, 1'b0);
    send_packet(seq_t'($urandom), $urandom, LEN_W'($urandom), 1'b1);
    send_packet(seq_t'(4), $urandom, '1, 1'b0);           // ignored after end
    send_packet(seq_t'(4), $urandom, '1, 1'b1);           // ignored after end
    settle(SETTLE_CYCLES);
    write_first_seq(31'h7FFF_FFFF);
    send_packet(seq_t'(0), $urandom, LEN_W'($urandom), 1'b0);
    send_packet(31'h7FFF_FFFF, $urandom, LEN_W'($urandom), 1'b0);  // releases across wrap
    settle(SETTLE_CYCLES);
    write_first_seq('0);
    send_packet(seq_t'(0), $urandom, LEN_W'($urandom), 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 70; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 70; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      settle(SETTLE_CYCLES);
      case (ph)
        1: write_first_seq(31'h7FFF_FFFF - seq_t'($urandom_range(0, 40)));
        2: write_first_seq(seq_t'($urandom_range(0, 20)));
        default: write_first_seq(seq_t'($urandom));
      endcase
      quota   = sent_words + WORDS_PER_PHASE;
      run_cnt = 0;
      while (sent_words < quota) begin
        if (ph == 0 && run_cnt == 0) send_run(WINDOW, 1'b1);
        else send_run($urandom_range(1, WINDOW), $urandom_range(99) < 25);
        run_cnt++;
        if (run_cnt == 2) settle(0);
      end
      send_packet(seq_t'($urandom), $urandom, LEN_W'($urandom), 1'b1);
      repeat ($urandom_range(1, 3)) begin
        send_packet(seq_t'($urandom), $urandom, LEN_W'($urandom), 1'($urandom_range(1)));
      end
    end

    settle(SETTLE_CYCLES);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sequence_reorder_buffer.f -----
+incdir+rtl
rtl/srb_pkg.sv
rtl/srb_if.sv
rtl/sequence_reorder_buffer.sv
tb/srb_checker.sv
tb/tb_sequence_reorder_buffer.sv
